// File: sv/taylor_trig_polynomial_top_defines.svh
// Assertion macros for the Maclaurin series trig block.
// Used by the top level only; needs nothing else.
`ifndef TAYLOR_TRIG_POLYNOMIAL_TOP_DEFINES_SVH
`define TAYLOR_TRIG_POLYNOMIAL_TOP_DEFINES_SVH

// Same-cycle implication, off during reset.
`define TTP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define TTP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ttp_pkg.sv
// Shared types, widths, codes and coefficient functions for the trig series block.
// No dependencies.
`default_nettype none

package ttp_pkg;

    // internal fixed point: Q30 with 32-bit angle
    localparam int FRAC      = 30;
    localparam int COEF_FRAC = 62;
    localparam int XW        = 32;          // internal angle width
    localparam int X2W       = 33;          // x squared magnitude, up to 4.0
    localparam int PW        = 48;          // power magnitude, up to 2^47
    localparam int PLO       = 32;          // low slice of power for p * x2
    localparam int CW        = 62;          // coefficient magnitude width
    localparam int PSPL      = 24;          // power slice for p * coef
    localparam int CSPL      = 31;          // coefficient slice for p * coef
    localparam int SUMW      = 48;          // signed accumulator width
    localparam int N_CELLS   = 8;           // terms after the leading one

    localparam logic [1:0] CMD_SIN  = 2'd0;
    localparam logic [1:0] CMD_COS  = 2'd1;
    localparam logic [1:0] CMD_TAN  = 2'd2;
    localparam logic [1:0] CMD_NONE = 2'd3;

    localparam logic [1:0] TM_FIVE  = 2'd0;
    localparam logic [1:0] TM_SEVEN = 2'd1;
    localparam logic [1:0] TM_NINE  = 2'd2;

    typedef struct packed {
        logic [1:0]             cmd;
        logic [1:0]             mode;
        logic [X2W-1:0]         x2;
        logic [PW-1:0]          pmag;
        logic                   psgn;
        logic signed [SUMW-1:0] acc;
    } t_beat;

    function automatic logic [3:0] term_count(input logic [1:0] mode);
        logic [3:0] n;
        case (mode)
            TM_FIVE:  n = 4'd5;
            TM_SEVEN: n = 4'd7;
            default:  n = 4'd9;
        endcase
        return n;
    endfunction

    function automatic logic [63:0] fact_odd(input logic [3:0] k);
        logic [63:0] v;
        case (k)
            4'd1:    v = 64'd6;
            4'd2:    v = 64'd120;
            4'd3:    v = 64'd5040;
            4'd4:    v = 64'd362880;
            4'd5:    v = 64'd39916800;
            4'd6:    v = 64'd6227020800;
            4'd7:    v = 64'd1307674368000;
            4'd8:    v = 64'd355687428096000;
            default: v = 64'd1;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] fact_even(input logic [3:0] k);
        logic [63:0] v;
        case (k)
            4'd1:    v = 64'd2;
            4'd2:    v = 64'd24;
            4'd3:    v = 64'd720;
            4'd4:    v = 64'd40320;
            4'd5:    v = 64'd3628800;
            4'd6:    v = 64'd479001600;
            4'd7:    v = 64'd87178291200;
            4'd8:    v = 64'd20922789888000;
            default: v = 64'd1;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] tan_num(input logic [3:0] k);
        logic [63:0] v;
        case (k)
            4'd1:    v = 64'd1;
            4'd2:    v = 64'd2;
            4'd3:    v = 64'd17;
            4'd4:    v = 64'd62;
            4'd5:    v = 64'd1382;
            4'd6:    v = 64'd21844;
            4'd7:    v = 64'd929569;
            4'd8:    v = 64'd6404582;
            default: v = 64'd1;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] tan_den(input logic [3:0] k);
        logic [63:0] v;
        case (k)
            4'd1:    v = 64'd3;
            4'd2:    v = 64'd15;
            4'd3:    v = 64'd315;
            4'd4:    v = 64'd2835;
            4'd5:    v = 64'd155925;
            4'd6:    v = 64'd6081075;
            4'd7:    v = 64'd638512875;
            4'd8:    v = 64'd10854718875;
            default: v = 64'd1;
        endcase
        return v;
    endfunction

    // round(num * 2^62 / den), ties up, for num < den; elaboration-time only
    function automatic logic [63:0] coef_q62(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = num;
        for (int i = 0; i < COEF_FRAC; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'd1;
            end
        end
        r = r << 1;
        if (r >= den) begin
            q = q + 64'd1;
        end
        return q;
    endfunction

endpackage

`default_nettype wire

// File: sv/ttp_front.sv
// Front end: angle width conversion, x squared and the leading series term.
// Depends on ttp_pkg.
`default_nettype none

module ttp_front import ttp_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_vld,
    input  wire logic [1:0]            i_cmd,
    input  wire logic [1:0]            i_mode,
    input  wire logic [DATA_WIDTH-1:0] i_angle,
    output t_beat                      o_beat,
    output logic                       o_vld
);

    localparam logic [63:0]            RND_SQ  = 64'd1 << (FRAC - 1);
    localparam logic [PW-1:0]          ONE_P   = PW'(1) << FRAC;
    localparam logic signed [SUMW-1:0] ONE_ACC = SUMW'(1) << FRAC;

    logic signed [XW-1:0] w_x;
    logic                 r_vld1;
    logic                 r_vld2;
    logic [1:0]           r_cmd;
    logic [1:0]           r_mode;
    logic signed [XW-1:0] r_x;
    logic [XW-1:0]        w_xmag;
    logic [63:0]          w_sq;
    t_beat                n_beat;
    t_beat                r_beat;

    generate
        if (DATA_WIDTH >= XW) begin : g_narrow
            logic signed [DATA_WIDTH-1:0] w_sh;
            // floor shift down to the internal Q30 word
            assign w_sh = $signed(i_angle) >>> (DATA_WIDTH - XW);
            assign w_x  = w_sh[XW-1:0];
        end else begin : g_widen
            assign w_x = {i_angle, {(XW - DATA_WIDTH){1'b0}}};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cmd  <= i_cmd;
            r_mode <= i_mode;
            r_x    <= w_x;
            r_beat <= n_beat;
        end
    end

    always_comb begin
        w_xmag = r_x[XW-1] ? XW'(-r_x) : XW'(r_x);
        w_sq   = (64'(w_xmag) * 64'(w_xmag)) + RND_SQ;
        n_beat.cmd  = r_cmd;
        n_beat.mode = r_mode;
        n_beat.x2   = w_sq[FRAC +: X2W];
        if (r_cmd == CMD_COS) begin
            n_beat.pmag = ONE_P;
            n_beat.psgn = 1'b0;
            n_beat.acc  = ONE_ACC;
        end else begin
            n_beat.pmag = PW'(w_xmag);
            n_beat.psgn = r_x[XW-1];
            n_beat.acc  = SUMW'(r_x);
        end
    end

    assign o_beat = r_beat;
    assign o_vld  = r_vld2;

endmodule

`default_nettype wire

// File: sv/ttp_cell.sv
// One series term cell: next power p*x2, term p*coef, accumulate; six stages.
// Depends on ttp_pkg.
`default_nettype none

module ttp_cell import ttp_pkg::*; #(
    parameter int CELL_IDX = 1
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_vld,
    input  t_beat      i_beat,
    output logic       o_vld,
    output t_beat      o_beat
);

    localparam logic [3:0]  K        = 4'(CELL_IDX);
    localparam logic [63:0] C_SIN_W  = coef_q62(64'd1, fact_odd(K));
    localparam logic [63:0] C_COS_W  = coef_q62(64'd1, fact_even(K));
    localparam logic [63:0] C_TAN_W  = coef_q62(tan_num(K), tan_den(K));
    localparam logic [CW-1:0] C_SIN  = C_SIN_W[CW-1:0];
    localparam logic [CW-1:0] C_COS  = C_COS_W[CW-1:0];
    localparam logic [CW-1:0] C_TAN  = C_TAN_W[CW-1:0];
    localparam logic          ODD_K  = (CELL_IDX % 2) == 1;
    localparam int            PROW   = PW + X2W;
    localparam int            MW     = PSPL + CSPL;
    localparam int            SW     = PSPL + 2 * CSPL;
    localparam int            TW     = PW + CW;
    localparam logic [PROW-1:0] RND_P = PROW'(1) << (FRAC - 1);
    localparam logic [TW-1:0]   RND_T = TW'(1) << (COEF_FRAC - 1);

    logic [5:0]              r_vld;
    logic [PLO+X2W-1:0]      r_pp_lo;
    logic [PW-PLO+X2W-1:0]   r_pp_hi;
    t_beat                   r_b1, r_b2, r_b3, r_b4, r_b5, r_b6;
    logic [PROW-1:0]         w_prod;
    t_beat                   n_b2;
    logic [CW-1:0]           n_coef;
    logic                    n_neg;
    logic [CW-1:0]           r_coef;
    logic                    r_neg2, r_neg3, r_neg4, r_neg5;
    logic                    r_act2, r_act3, r_act4, r_act5;
    logic [MW-1:0]           r_m00, r_m01, r_m10, r_m11;
    logic [SW-1:0]           r_slo, r_shi;
    logic [TW-1:0]           w_tot;
    logic [PW-1:0]           r_term;
    logic signed [SUMW-1:0]  w_tsig;
    t_beat                   n_b6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_vld};
        end
    end

    // next power: split p so each product stays near 32 by 32
    always_comb begin
        w_prod = {r_pp_hi, {PLO{1'b0}}} + PROW'(r_pp_lo) + RND_P;
        n_b2 = r_b1;
        n_b2.pmag = w_prod[FRAC +: PW];
        case (r_b1.cmd)
            CMD_SIN: n_coef = C_SIN;
            CMD_COS: n_coef = C_COS;
            default: n_coef = C_TAN;
        endcase
        n_neg = r_b1.psgn ^ (ODD_K && (r_b1.cmd != CMD_TAN));
    end

    always_comb begin
        w_tot  = {r_shi, {PSPL{1'b0}}} + TW'(r_slo) + RND_T;
        w_tsig = r_neg5 ? -SUMW'(r_term) : SUMW'(r_term);
        n_b6 = r_b5;
        // hold the sum once the series has run out of terms
        if (r_act5) begin
            n_b6.acc = r_b5.acc + w_tsig;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b1    <= i_beat;
            r_pp_lo <= i_beat.pmag[PLO-1:0] * i_beat.x2;
            r_pp_hi <= i_beat.pmag[PW-1:PLO] * i_beat.x2;

            r_b2    <= n_b2;
            r_coef  <= n_coef;
            r_neg2  <= n_neg;
            r_act2  <= K < term_count(r_b1.mode);

            r_b3    <= r_b2;
            r_neg3  <= r_neg2;
            r_act3  <= r_act2;
            r_m00   <= r_b2.pmag[PSPL-1:0]  * r_coef[CSPL-1:0];
            r_m01   <= r_b2.pmag[PSPL-1:0]  * r_coef[CW-1:CSPL];
            r_m10   <= r_b2.pmag[PW-1:PSPL] * r_coef[CSPL-1:0];
            r_m11   <= r_b2.pmag[PW-1:PSPL] * r_coef[CW-1:CSPL];

            r_b4    <= r_b3;
            r_neg4  <= r_neg3;
            r_act4  <= r_act3;
            r_slo   <= SW'(r_m00) + {r_m01, {CSPL{1'b0}}};
            r_shi   <= SW'(r_m10) + {r_m11, {CSPL{1'b0}}};

            r_b5    <= r_b4;
            r_neg5  <= r_neg4;
            r_act5  <= r_act4;
            r_term  <= w_tot[COEF_FRAC +: PW];

            r_b6    <= n_b6;
        end
    end

    assign o_vld  = r_vld[5];
    assign o_beat = r_b6;

endmodule

`default_nettype wire

// File: sv/ttp_back.sv
// Back end: convert the Q30 sum to the output width and saturate; no command gives zero.
// Depends on ttp_pkg.
`default_nettype none

module ttp_back import ttp_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_vld,
    input  t_beat                       i_beat,
    output logic                        o_vld,
    output logic [DATA_WIDTH-1:0]       o_value,
    output logic                        o_ovf
);

    localparam logic [DATA_WIDTH-1:0] SAT_HI = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] SAT_LO = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

    logic [DATA_WIDTH-1:0] w_val;
    logic                  w_ovf;
    logic                  w_in_range;
    logic                  w_neg;
    logic                  r_vld;
    logic [DATA_WIDTH-1:0] r_value;
    logic                  r_ovf;

    generate
        if (DATA_WIDTH >= XW) begin : g_scale_up
            logic [DATA_WIDTH-1:0] w_scaled;
            assign w_in_range = i_beat.acc[SUMW-1:XW-1] == {(SUMW - XW + 1){i_beat.acc[XW-1]}};
            assign w_neg      = i_beat.acc[SUMW-1];
            assign w_scaled   = DATA_WIDTH'($signed(i_beat.acc[XW-1:0])) << (DATA_WIDTH - XW);
            assign w_val      = w_scaled;
        end else begin : g_scale_down
            localparam int SH = XW - DATA_WIDTH;
            logic signed [SUMW-1:0] w_rnd;
            logic signed [SUMW-1:0] w_res;
            assign w_rnd      = i_beat.acc + (SUMW'(1) << (SH - 1));
            assign w_res      = w_rnd >>> SH;
            assign w_in_range = w_res[SUMW-1:DATA_WIDTH-1]
                                == {(SUMW - DATA_WIDTH + 1){w_res[DATA_WIDTH-1]}};
            assign w_neg      = w_res[SUMW-1];
            assign w_val      = w_res[DATA_WIDTH-1:0];
        end
    endgenerate

    assign w_ovf = !w_in_range && (i_beat.cmd != CMD_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf <= w_ovf;
            if (i_beat.cmd == CMD_NONE) begin
                r_value <= '0;
            end else if (!w_in_range) begin
                r_value <= w_neg ? SAT_LO : SAT_HI;
            end else begin
                r_value <= w_val;
            end
        end
    end

    assign o_vld   = r_vld;
    assign o_value = r_value;
    assign o_ovf   = r_ovf;

endmodule

`default_nettype wire

// File: sv/taylor_trig_polynomial_top.sv
// Stages from the accepting edge to m_axis_tvalid:
//   2 front stages, 8 term cells of 6 stages each, 1 back stage, 1 output register.
// Throughput: one beat per cycle while the skid entry is free; every stage holds while it is full.
// A two-entry output buffer keeps input accepted while one result waits.
// Reset (synchronous, active low) clears all valid bits; term_mode returns to nine terms.
`default_nettype none
`include "taylor_trig_polynomial_top_defines.svh"

module taylor_trig_polynomial_top import ttp_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_wdata,    // term_mode
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,  // angle
    input  wire logic [1:0]       s_axis_tuser,   // command
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,   // value
    output logic                  m_axis_tuser    // overflow
);

    localparam int TDW = ((DATA_WIDTH + 7) / 8) * 8;
    localparam logic [DATA_WIDTH-1:0] SAT_HI = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] SAT_LO = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

    logic [1:0]            r_term_mode;
    logic                  w_en;
    logic                  w_vld  [0:N_CELLS];
    t_beat                 w_beat [0:N_CELLS];
    logic                  w_last_vld;
    logic [DATA_WIDTH-1:0] w_last_value;
    logic                  w_last_ovf;
    logic                  r_out_vld;
    logic [DATA_WIDTH-1:0] r_out_value;
    logic                  r_out_ovf;
    logic                  r_skid_vld;
    logic [DATA_WIDTH-1:0] r_skid_value;
    logic                  r_skid_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_mode <= TM_NINE;
        end else if (i_cfg_we) begin
            r_term_mode <= i_cfg_wdata;
        end
    end

    // the whole row advances while the skid entry is free
    assign w_en          = !r_skid_vld;
    assign s_axis_tready = w_en;

    ttp_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (s_axis_tvalid),
        .i_cmd   (s_axis_tuser),
        .i_mode  (r_term_mode),
        .i_angle (s_axis_tdata[DATA_WIDTH-1:0]),
        .o_beat  (w_beat[0]),
        .o_vld   (w_vld[0])
    );

    generate
        for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
            ttp_cell #(.CELL_IDX(g + 1)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_vld   (w_vld[g]),
                .i_beat  (w_beat[g]),
                .o_vld   (w_vld[g+1]),
                .o_beat  (w_beat[g+1])
            );
        end
    endgenerate

    ttp_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_vld[N_CELLS]),
        .i_beat  (w_beat[N_CELLS]),
        .o_vld   (w_last_vld),
        .o_value (w_last_value),
        .o_ovf   (w_last_ovf)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (w_en) begin
            if (!r_out_vld || m_axis_tready) begin
                r_out_vld <= w_last_vld;
            end else if (w_last_vld) begin
                r_skid_vld <= 1'b1;
            end
        end else if (m_axis_tready) begin
            r_skid_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (!r_out_vld || m_axis_tready) begin
                r_out_value <= w_last_value;
                r_out_ovf   <= w_last_ovf;
            end else begin
                r_skid_value <= w_last_value;
                r_skid_ovf   <= w_last_ovf;
            end
        end else if (m_axis_tready) begin
            // drain the skid beat into the output register
            r_out_value <= r_skid_value;
            r_out_ovf   <= r_skid_ovf;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = TDW'(r_out_value);
    assign m_axis_tuser  = r_out_ovf;

    `TTP_ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, r_skid_vld, r_out_vld,
        "skid holds a beat while the output register is empty")
    `TTP_ASSERT_NEXT(a_skid_catch, i_clk, i_rst_n,
        r_out_vld && !m_axis_tready && w_en && w_last_vld, r_skid_vld,
        "stalled result was not caught by the skid entry")
    `TTP_ASSERT_IMPL(a_ovf_saturated, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser,
        r_out_value == SAT_HI || r_out_value == SAT_LO,
        "overflow flagged on a value that is not saturated")

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking bench for taylor_trig_polynomial_top: sine, cosine and tangent series.
// Predicts every result at the accepting edge and checks the stream in order.
// Depends on ttp_pkg and the top level only.
`timescale 1ns / 100ps

module testbench import ttp_pkg::*;;

    localparam int DW = 32;
    localparam logic [1:0] TM_SPARE = 2'd3;    // unused code, behaves as nine terms
    localparam int MAX_REPORTS = 10;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 60;
    localparam logic [31:0] QUARTER_PI = 32'd843314857;
    localparam logic [31:0] HALF_PI = 32'd1686629713;

    typedef struct packed {
        logic [1:0]  fn;
        logic [31:0] angle;
    } t_angle_req;

    typedef struct packed {
        logic [1:0]  fn;
        logic [31:0] angle;
        logic [31:0] value;
        logic        ovf;
    } t_series_res;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_we = 1'b0;
    logic [1:0]    i_cfg_wdata = TM_NINE;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [DW-1:0] s_axis_tdata = '0;         // angle
    logic [1:0]    s_axis_tuser = CMD_SIN;    // command
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [DW-1:0] m_axis_tdata;              // value
    logic          m_axis_tuser;              // overflow

    t_angle_req  angle_queue [$];
    t_series_res sums_due [$];
    t_angle_req  next_angle;
    t_series_res got_sum;
    logic [63:0] coef_tab [0:2][1:8];
    logic [1:0]  term_len;
    int          angles_queued = 0;
    int          angles_taken = 0;
    int          mismatches = 0;
    bit          src_idle_en = 1'b0;
    bit          snk_idle_en = 1'b0;
    bit          hold_go = 1'b0;
    logic        sink_hold = 1'b0;
    int          src_wait;
    int          snk_wait;
    int          gap;

    taylor_trig_polynomial_top #(
        .DATA_WIDTH(DW)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    // Signed value times a magnitude, shifted right with rounding on the magnitude.
    function automatic longint mul_round(input longint a, input logic [63:0] bmag,
                                         input logic bneg, input int sh);
        logic [127:0] prod;
        logic [63:0]  amag;
        logic [63:0]  r;
        amag = (a < 0) ? 64'(-a) : 64'(a);
        prod = {64'd0, amag} * {64'd0, bmag};
        prod = prod + (128'd1 << (sh - 1));
        r = 64'(prod >> sh);
        return ((a < 0) != bneg) ? -longint'(r) : longint'(r);
    endfunction

    function automatic t_series_res series_value(input logic [1:0] fn,
                                                 input logic [31:0] angle,
                                                 input logic [1:0] len);
        t_series_res res;
        longint      x;
        longint      x2;
        longint      pw;
        longint      acc;
        int          n_terms;
        res.fn = fn;
        res.angle = angle;
        res.value = '0;
        res.ovf = 1'b0;
        if (fn == CMD_NONE) return res;
        x = longint'($signed(angle));
        n_terms = (len == TM_FIVE) ? 5 : ((len == TM_SEVEN) ? 7 : 9);
        x2 = mul_round(x, 64'((x < 0) ? -x : x), x < 0, FRAC);
        pw = (fn == CMD_COS) ? (longint'(1) << FRAC) : x;
        acc = pw;
        for (int k = 1; k < n_terms; k++) begin
            pw = mul_round(pw, 64'(x2), 1'b0, FRAC);
            acc = acc + mul_round(pw, coef_tab[fn][k], (fn != CMD_TAN) && (k % 2 == 1),
                                  COEF_FRAC);
        end
        if (acc > 64'sd2147483647) begin
            res.value = 32'h7FFF_FFFF;
            res.ovf = 1'b1;
        end else if (acc < -64'sd2147483648) begin
            res.value = 32'h8000_0000;
            res.ovf = 1'b1;
        end else begin
            res.value = acc[31:0];
        end
        return res;
    endfunction

    // Q62 series coefficients, rounded to nearest with ties up.
    initial begin
        logic [127:0] num;
        logic [127:0] den;
        for (int f = 0; f < 3; f++) begin
            for (int k = 1; k < 9; k++) begin
                num = 128'd1;
                den = 128'd1;
                if (f == CMD_TAN) begin
                    case (k)
                        1: begin num = 128'd1;       den = 128'd3;           end
                        2: begin num = 128'd2;       den = 128'd15;          end
                        3: begin num = 128'd17;      den = 128'd315;         end
                        4: begin num = 128'd62;      den = 128'd2835;        end
                        5: begin num = 128'd1382;    den = 128'd155925;      end
                        6: begin num = 128'd21844;   den = 128'd6081075;     end
                        7: begin num = 128'd929569;  den = 128'd638512875;   end
                        default: begin num = 128'd6404582; den = 128'd10854718875; end
                    endcase
                end else begin
                    for (int i = 2; i <= 2 * k + ((f == CMD_SIN) ? 1 : 0); i++) begin
                        den = den * i;
                    end
                end
                coef_tab[f][k] = 64'((((num << 63) / den) + 128'd1) >> 1);
            end
        end
    end

    task automatic note_fault(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("%s", msg);
    endtask

    // Source side: one beat per queued angle, random gap after each when src_idle_en is set.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_wait <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (src_wait != 0) begin
                src_wait <= src_wait - 1;
                s_axis_tvalid <= 1'b0;
            end else if (angle_queue.size() != 0) begin
                next_angle = angle_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= next_angle.angle;
                s_axis_tuser <= next_angle.fn;
                src_wait <= src_idle_en ? $urandom_range(0, 13) : 0;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Sink side: random stall after each beat when snk_idle_en is set, plus the long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            snk_wait <= 0;
        end else if (sink_hold) begin
            m_axis_tready <= 1'b0;
        end else if (snk_wait != 0) begin
            snk_wait <= snk_wait - 1;
            m_axis_tready <= (snk_wait == 1);
        end else if (m_axis_tvalid && m_axis_tready) begin
            gap = snk_idle_en ? $urandom_range(0, 13) : 0;
            snk_wait <= gap;
            m_axis_tready <= (gap == 0);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Track the term setting, predict on accepted angles, check returned beats.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            term_len <= TM_NINE;
        end else begin
            if (i_cfg_we) term_len <= i_cfg_wdata;
            if (m_axis_tvalid && m_axis_tready) begin
                if (sums_due.size() == 0) begin
                    note_fault($sformatf("unexpected beat: value %h ovf %b",
                                         m_axis_tdata, m_axis_tuser));
                end else begin
                    got_sum = sums_due.pop_front();
                    if (m_axis_tdata !== got_sum.value || m_axis_tuser !== got_sum.ovf)
                        note_fault($sformatf(
                            "mismatch cmd %0d angle %h: expected %h ovf %b, got %h ovf %b",
                            got_sum.fn, got_sum.angle, got_sum.value, got_sum.ovf,
                            m_axis_tdata, m_axis_tuser));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sums_due.push_back(series_value(s_axis_tuser, s_axis_tdata, term_len));
                angles_taken++;
            end
        end
    end

    task automatic offer(input logic [1:0] fn, input logic [31:0] angle);
        t_angle_req req;
        req.fn = fn;
        req.angle = angle;
        angle_queue.push_back(req);
        angles_queued++;
    endtask

    task automatic drain(input int settle);
        while (angles_taken != angles_queued || sums_due.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic set_terms(input logic [1:0] len);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= len;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly reduced angles, some out to half pi, the rest anywhere in range.
    task automatic offer_random(input int count);
        logic [1:0]  fn;
        logic [31:0] mag;
        int          pick;
        for (int i = 0; i < count; i++) begin
            fn = ($urandom_range(0, 9) == 0) ? CMD_NONE : 2'($urandom_range(0, 2));
            pick = $urandom_range(0, 9);
            if (pick < 6) mag = $urandom_range(0, QUARTER_PI);
            else if (pick < 8) mag = $urandom_range(0, HALF_PI);
            else mag = $urandom;
            if (pick < 8 && $urandom_range(0, 1) == 1) mag = -mag;
            offer(fn, mag);
        end
    endtask

    initial begin
        logic [1:0]  phase_len [0:5];
        logic [31:0] corner;
        phase_len[0] = TM_FIVE;
        phase_len[1] = TM_SEVEN;
        phase_len[2] = TM_SPARE;
        phase_len[3] = TM_NINE;
        phase_len[4] = TM_FIVE;
        phase_len[5] = TM_NINE;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Corner angles at the reset setting: zero, extremes, one, smallest steps.
        for (int f = CMD_SIN; f <= CMD_TAN; f++) begin
            for (int i = 0; i < 7; i++) begin
                case (i)
                    0: corner = 32'h0000_0000;
                    1: corner = 32'h7FFF_FFFF;
                    2: corner = 32'h8000_0000;
                    3: corner = 32'h4000_0000;
                    4: corner = 32'hC000_0000;
                    5: corner = 32'h0000_0001;
                    default: corner = 32'hFFFF_FFFF;
                endcase
                offer(2'(f), corner);
            end
        end
        offer(CMD_NONE, 32'h7FFF_FFFF);
        offer(CMD_NONE, 32'h8000_0000);
        drain(4);

        for (int p = 0; p < 6; p++) begin
            set_terms(phase_len[p]);
            src_idle_en = (p % 3 != 0);
            snk_idle_en = (p % 2 == 1);
            if (p == 0) hold_go = 1'b1;
            offer_random(100);
            drain(4);
        end

        drain(SETTLE_CYCLES);
        if (sums_due.size() != 0)
            note_fault($sformatf("%0d results never arrived", sums_due.size()));
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Stall the sink long enough for the pipeline to back up into the source.
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        sink_hold <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
